/* hw/rtl/stwc_pkg.sv */
// Package of the scrolling text window controller.
// Holds the sizes, codes and item types shared by its modules but the RAM.
package stwc_pkg;

    localparam int LINE_BYTES  = 32;
    localparam int DIGITS      = 4;
    localparam int IDX_W       = $clog2(LINE_BYTES);
    localparam int OFF_W       = IDX_W + 1;
    localparam int DIG_W       = $clog2(DIGITS);
    localparam int RAM_DEPTH   = 2 * LINE_BYTES;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic       OP_CHAR    = 1'b0;
    localparam logic       OP_TICK    = 1'b1;
    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] SPACE_CODE = 8'h20;

    localparam logic signed [OFF_W-1:0] HOLD_OFFSET = OFF_W'(-4);

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       char_code;
        logic [DIG_W-1:0] digit_position;
        logic             last_of_frame;
    } t_out_item;

    typedef struct packed {
        logic             bank;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] len;
    } t_frame_cmd;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

endpackage

/* hw/rtl/stwc_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the line and text banks.
module stwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/stwc_cmd_queue.sv */
// Short queue of frame commands between the front and the back part.
// Depends on stwc_pkg for the command type and depth.
module stwc_cmd_queue
    import stwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_cmd i_cmd,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_frame_cmd o_cmd
);

    t_frame_cmd        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("Command pushed into a full queue.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("Command popped from an empty queue.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count out of range.");
`endif

endmodule

/* hw/rtl/stwc_front.sv */
// Front part: accepts items, gathers bytes into the line bank, swaps banks on
// a latch, steps the scroll offset and queues frame commands. Uses stwc_pkg.
module stwc_front
    import stwc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    input  logic       i_queue_full,
    input  logic       i_drained,
    output logic       o_push,
    output t_frame_cmd o_cmd,
    output t_ram_wr    o_wr
);

    logic [IDX_W-1:0]        r_fill;
    logic [IDX_W-1:0]        r_len;
    logic signed [OFF_W-1:0] r_off;
    logic                    r_bank;

    logic                    accept;
    logic                    is_char;
    logic                    ends;
    logic                    latch;
    logic                    tick_go;
    logic [IDX_W-1:0]        fill_base;
    logic [IDX_W-1:0]        n_fill;
    logic [IDX_W-1:0]        n_len;
    logic signed [OFF_W-1:0] n_off;
    logic                    n_bank;
    logic signed [OFF_W-1:0] len_s;
    logic signed [OFF_W-1:0] n_len_s;
    logic signed [OFF_W-1:0] lim_s;
    logic signed [OFF_W-1:0] start_s;

    assign is_char = (i_in_data.opcode == OP_CHAR);
    assign ends    = (i_in_data.char_byte == BYTE_NL) || (i_in_data.char_byte == BYTE_NUL);
    assign latch   = is_char && (((r_fill != '0) && ends)
                                 || (r_fill >= IDX_W'(LINE_BYTES - 1)));
    assign tick_go = !is_char && (r_len > IDX_W'(DIGITS));

    assign o_in_ready = !i_queue_full && (!latch || i_drained);
    assign accept     = i_in_valid && o_in_ready;

    assign len_s = signed'({1'b0, r_len});

    always_comb begin
        fill_base = latch ? '0 : r_fill;
        n_fill    = ends ? fill_base : fill_base + 1'b1;
        n_len     = latch ? r_fill : r_len;
        n_bank    = latch ? ~r_bank : r_bank;
        if (latch) begin
            n_off = HOLD_OFFSET;
        end else if ((r_off < 0) || (r_off < len_s - OFF_W'(DIGITS / 2))) begin
            n_off = r_off + 1'b1;
        end else begin
            n_off = HOLD_OFFSET;
        end
        n_len_s = signed'({1'b0, n_len});
        lim_s   = n_len_s - OFF_W'(DIGITS);
        if (n_off < 0) begin
            start_s = '0;
        end else if (n_off < lim_s) begin
            start_s = n_off;
        end else begin
            start_s = lim_s;
        end
        if (start_s < 0) begin
            start_s = '0;
        end
    end

    assign o_push      = accept && (latch || tick_go);
    assign o_cmd.bank  = n_bank;
    assign o_cmd.start = start_s[IDX_W-1:0];
    assign o_cmd.len   = n_len;

    assign o_wr.en   = accept && is_char && !ends;
    assign o_wr.addr = {~n_bank, fill_base};
    assign o_wr.data = i_in_data.char_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_len  <= '0;
            r_off  <= '0;
            r_bank <= 1'b0;
        end else if (accept) begin
            if (is_char) begin
                r_fill <= n_fill;
                r_len  <= n_len;
                r_bank <= n_bank;
                if (latch) begin
                    r_off <= n_off;
                end
            end else if (tick_go) begin
                r_off <= n_off;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_latch_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && latch) |-> i_drained)
        else $error("Bank swapped while frames of the old text were pending.");
`endif

endmodule

/* hw/rtl/stwc_back.sv */
// Back part: reads one character per cycle from the text bank for each queued
// frame unless stalled; an output register presents them. Uses stwc_pkg.
module stwc_back
    import stwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_frame_cmd        i_cmd,
    output logic              o_pop,
    output logic              o_busy,
    output logic              o_rd_en,
    output logic [RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    input  logic              i_rotate,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    t_frame_cmd       r_cmd;
    logic             r_active;
    logic [DIG_W-1:0] r_idx;
    logic             r_b_v;
    logic             r_b_space;
    logic [DIG_W-1:0] r_b_idx;
    logic             r_out_v;
    t_out_item        r_out;

    logic             out_adv;
    logic             b_moves;
    logic             issue;
    logic             last_issue;
    logic             load;
    logic [IDX_W:0]   pos;

    assign out_adv    = !r_out_v || i_out_ready;
    assign b_moves    = r_b_v && out_adv;
    assign issue      = r_active && (!r_b_v || b_moves);
    assign last_issue = issue && (r_idx == DIG_W'(DIGITS - 1));
    assign load       = i_cmd_valid && (!r_active || last_issue);

    assign pos       = {1'b0, r_cmd.start} + (IDX_W + 1)'(r_idx);
    assign o_rd_en   = issue;
    assign o_rd_addr = {r_cmd.bank, pos[IDX_W-1:0]};
    assign o_pop     = load;
    assign o_busy    = r_active;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_cmd;
        end
        if (issue) begin
            r_b_space <= (pos >= {1'b0, r_cmd.len});
            r_b_idx   <= r_idx;
        end
        if (b_moves) begin
            r_out.char_code      <= r_b_space ? SPACE_CODE : i_rd_data;
            r_out.digit_position <= i_rotate ? DIG_W'(DIGITS - 1) - r_b_idx : r_b_idx;
            r_out.last_of_frame  <= (r_b_idx == DIG_W'(DIGITS - 1));
        end
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_b_v    <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (load) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (last_issue) begin
                r_active <= 1'b0;
            end else if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (issue) begin
                r_b_v <= 1'b1;
            end else if (b_moves) begin
                r_b_v <= 1'b0;
            end
            if (out_adv) begin
                r_out_v <= r_b_v;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/scrolling_text_window_controller_unit.sv */
// Scrolling text window controller for a four-digit character display.
// Written bytes and scroll ticks enter on the input channel; each frame leaves
// as four character items on the output channel, the last one flagged.
// The rotate register is written on a separate channel that is always ready.
// The first character of a frame passes the command queue, the reader's
// command register, the memory's read register and the output register; the
// other three follow one per cycle while the receiver does not stall, as the
// single read port of the text memory gives one character per cycle.
// Ticks and ordinary bytes are taken back to back while earlier frames drain.
// A byte that ends a line or meets a full line is held off until every queued
// frame has been read, since the line and text banks then swap.
// When the receiver stalls, the output register holds its character, the
// reader pauses, and the two-entry command queue fills before input stalls.
// Reset clears the line, the text length, the scroll offset and the rotate
// register; no frame is pending afterwards and no clearing pass is needed.
module scrolling_text_window_controller_unit
    import stwc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    logic              r_rotate;
    logic              q_full;
    logic              q_valid;
    logic              push;
    logic              pop;
    logic              back_busy;
    logic              drained;
    t_frame_cmd        push_cmd;
    t_frame_cmd        head_cmd;
    t_ram_wr           wr;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign o_cfg_ready = 1'b1;
    assign drained     = !q_valid && !back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotate <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rotate <= i_cfg_data;
        end
    end

    stwc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_queue_full (q_full),
        .i_drained    (drained),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_wr         (wr)
    );

    stwc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    stwc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    stwc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_busy      (back_busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .i_rotate    (r_rotate),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* tb/stwc_frame_checker.sv */
`timescale 1ns / 1ps
// Frame checker for the scrolling text window controller testbench.
// Watches the input, output and rotate channels, predicts each frame of
// characters and compares them; depends on stwc_pkg only.
module stwc_frame_checker
    import stwc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic      i_cfg_data,
    output int        o_pending,
    output int        o_errors
);

    logic [7:0] line_buf [LINE_BYTES];
    logic [7:0] shown_text [LINE_BYTES];
    int         line_count = 0;
    int         shown_len = 0;
    int         window_offset = 0;
    logic       rotate = 1'b0;
    int         errors = 0;
    t_out_item  expected_chars [$];
    t_out_item  want;

    function automatic void queue_frame();
        int        first;
        t_out_item c;
        if (window_offset < 0) begin
            first = 0;
        end else if (window_offset < shown_len - DIGITS) begin
            first = window_offset;
        end else begin
            first = shown_len - DIGITS;
        end
        if (first < 0) begin
            first = 0;
        end
        for (int i = 0; i < DIGITS; i++) begin
            c.char_code = (first + i < shown_len) ? shown_text[IDX_W'(first + i)]
                                                  : SPACE_CODE;
            c.digit_position = rotate ? DIG_W'(DIGITS - 1 - i) : DIG_W'(i);
            c.last_of_frame = (i == DIGITS - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic void predict_item(input t_in_item item);
        logic stop;
        stop = (item.char_byte == BYTE_NL) || (item.char_byte == BYTE_NUL);
        if (item.opcode == OP_CHAR) begin
            if ((line_count > 0 && stop) || line_count >= LINE_BYTES - 1) begin
                for (int k = 0; k < line_count; k++) begin
                    shown_text[IDX_W'(k)] = line_buf[IDX_W'(k)];
                end
                shown_len = line_count;
                line_count = 0;
                window_offset = HOLD_OFFSET;
                queue_frame();
            end
            if (!stop && line_count < LINE_BYTES) begin
                line_buf[IDX_W'(line_count)] = item.char_byte;
                line_count++;
            end
        end else if (shown_len > DIGITS) begin
            if (window_offset < shown_len - DIGITS / 2) begin
                window_offset++;
            end else begin
                window_offset = HOLD_OFFSET;
            end
            queue_frame();
        end
    endfunction

    function automatic void check_field(input string what, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            line_count = 0;
            shown_len = 0;
            window_offset = 0;
            rotate = 1'b0;
            expected_chars.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rotate = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                predict_item(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected character item: expected none, got %h",
                             $time, i_out_data);
                end else begin
                    want = expected_chars.pop_front();
                    check_field("char_code", want.char_code, i_out_data.char_code);
                    check_field("digit_position", 8'(want.digit_position),
                                8'(i_out_data.digit_position));
                    check_field("last_of_frame", 8'(want.last_of_frame),
                                8'(i_out_data.last_of_frame));
                end
            end
        end
        o_pending <= expected_chars.size();
        o_errors <= errors;
    end

endmodule

/* tb/scrolling_text_window_controller_unit_test.sv */
`timescale 1ns / 1ps
// Top of the scrolling text window controller testbench.
// Drives bytes, ticks and rotate writes into the block and gives the verdict;
// depends on stwc_pkg, the block and stwc_frame_checker.
module scrolling_text_window_controller_unit_test;
    import stwc_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SQUEEZE_CYCLES = 80;
    localparam int PHASE_ITEMS    = 85;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b1;
    t_out_item out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;
    int        pending;
    int        errors;

    logic      sender_gaps = 1'b1;
    logic      receiver_gaps = 1'b1;
    logic      squeeze = 1'b0;
    logic      squeezed = 1'b0;
    int        stall_left = 0;
    int        cycle_count = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    scrolling_text_window_controller_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    stwc_frame_checker frame_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    always @(posedge clk) begin
        if (squeeze && !squeezed) begin
            squeezed <= 1'b1;
            stall_left <= SQUEEZE_CYCLES;
            out_ready <= 1'b0;
        end else begin
            if (!squeeze) begin
                squeezed <= 1'b0;
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 6);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic offer(input logic op, input logic [7:0] data);
        t_in_item item;
        item.opcode = op;
        item.char_byte = data;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    task automatic write_line(input int len);
        logic [7:0] b;
        for (int n = 0; n < len; n++) begin
            b = 8'($urandom_range(1, 255));
            if (b == BYTE_NL) begin
                b = 8'hA5;
            end
            offer(OP_CHAR, b);
        end
        offer(OP_CHAR, $urandom_range(0, 1) ? BYTE_NL : BYTE_NUL);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) offer(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_rotate(input logic value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int target, input logic with_squeeze);
        int useful;
        int len;
        int ticks;
        int r;
        useful = 0;
        while (useful < target) begin
            if (with_squeeze && useful > target / 2) begin
                with_squeeze = 1'b0;
                sender_gaps = 1'b0;
                squeeze <= 1'b1;
                write_line(12);
                send_ticks(20);
                squeeze <= 1'b0;
                sender_gaps = 1'b1;
                useful += 33;
            end else if ($urandom_range(0, 99) < 75) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    len = $urandom_range(1, 10);
                end else if (r < 9) begin
                    len = $urandom_range(11, 30);
                end else begin
                    len = $urandom_range(31, 34);
                end
                ticks = $urandom_range(0, len + 8);
                write_line(len);
                send_ticks(ticks);
                useful += len + 1 + ((len > DIGITS) ? ticks : 0);
            end else begin
                repeat ($urandom_range(2, 8)) begin
                    offer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        set_rotate(1'b0);

        offer(OP_TICK, 8'hFF);
        offer(OP_CHAR, BYTE_NL);
        offer(OP_CHAR, BYTE_NUL);
        offer(OP_CHAR, 8'h41);
        offer(OP_CHAR, 8'h42);
        offer(OP_CHAR, BYTE_NUL);
        offer(OP_TICK, 8'h00);
        offer(OP_CHAR, 8'hFF);
        offer(OP_CHAR, 8'h01);
        offer(OP_CHAR, 8'h80);
        offer(OP_CHAR, 8'h7F);
        offer(OP_CHAR, 8'h55);
        offer(OP_CHAR, BYTE_NL);
        send_ticks(9);

        set_rotate(1'b1);
        random_phase(PHASE_ITEMS, 1'b1);
        set_rotate(1'b0);
        random_phase(PHASE_ITEMS, 1'b0);
        set_rotate(1'b1);
        random_phase(PHASE_ITEMS, 1'b0);
        set_rotate(1'b0);
        sender_gaps = 1'b0;
        receiver_gaps <= 1'b0;
        random_phase(PHASE_ITEMS, 1'b0);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
